// ===== design/lcdw_pkg.sv =====
// shared types and constants of the character lcd write sequencer
package lcdw_pkg;

   // host commands
   typedef enum logic [2:0] {
      CMD_INIT     = 3'd0,
      CMD_CLEAR    = 3'd1,
      CMD_CHAR_AT  = 3'd2,
      CMD_STR_CHAR = 3'd3,
      CMD_STR_END  = 3'd4
   } cmd_type;

   // configuration register indexes
   localparam logic REG_SETUP_TICKS  = 1'b0;
   localparam logic REG_ENABLE_TICKS = 1'b1;

   localparam logic [15:0] SETUP_TICKS_RESET  = 16'd550;
   localparam logic [15:0] ENABLE_TICKS_RESET = 16'd550;

   // lcd command bytes
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h38;
   localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_LINE1_BASE   = 8'h80;
   localparam logic [7:0] LCD_LINE2_BASE   = 8'hC0;
   localparam logic [1:0] ROW_BOTTOM       = 2'd2;

   localparam int MAX_WRITES = 4;

   typedef struct packed {
      logic [2:0] cmd;
      logic [1:0] row;
      logic [4:0] column;
      logic [7:0] char_code;
      logic       string_start;
   } req_item_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_item_type;

   // bus writes caused by one host item
   typedef struct packed {
      logic [2:0]                        count;
      rsp_item_type [MAX_WRITES-1:0]     writes;
   } write_list_type;

   function automatic rsp_item_type bus_write(input logic is_data, input logic [7:0] value);
      rsp_item_type w;
      w.is_data  = is_data;
      w.bus_byte = value;
      w.last     = 1'b0;
      return w;
   endfunction

   function automatic logic [7:0] line_address(input logic [1:0] row,
                                               input logic [4:0] column);
      logic [7:0] base;
      base = (row == ROW_BOTTOM) ? LCD_LINE2_BASE : LCD_LINE1_BASE;
      return base + {3'b000, column} + 8'hFF;
   endfunction

endpackage

// ===== design/lcdw_csr.sv =====
// apb register file holding the lcd bus timing
module lcdw_csr
   import lcdw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] setup_ticks_ff, setup_ticks_in;
   logic [15:0] enable_ticks_ff, enable_ticks_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      setup_ticks_in  = setup_ticks_ff;
      enable_ticks_in = enable_ticks_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SETUP_TICKS:  setup_ticks_in  = csr_pwdata[15:0];
            REG_ENABLE_TICKS: enable_ticks_in = csr_pwdata[15:0];
            default:          setup_ticks_in  = setup_ticks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ticks_ff  <= SETUP_TICKS_RESET;
         enable_ticks_ff <= ENABLE_TICKS_RESET;
      end else begin
         setup_ticks_ff  <= setup_ticks_in;
         enable_ticks_ff <= enable_ticks_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SETUP_TICKS:  csr_prdata = {16'd0, setup_ticks_ff};
         REG_ENABLE_TICKS: csr_prdata = {16'd0, enable_ticks_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== design/lcdw_expand.sv =====
// expands one host item into its bus writes and keeps the string state
module lcdw_expand
   import lcdw_pkg::*;
#(
   parameter int LINE_CHARS = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  req_item_type   item,
   input  logic           commit,
   output write_list_type list
);

   localparam int CW = $clog2(LINE_CHARS + 1);
   localparam logic [CW-1:0] LINE_LAST = CW'(LINE_CHARS);

   logic [7:0]    address_ff, address_in;
   logic [CW-1:0] count_ff, count_in;
   logic          done_ff, done_in;

   logic [7:0]    pos_address;
   logic          load_start;
   logic [7:0]    cur_address;
   logic [CW-1:0] cur_count;
   logic [CW-1:0] count_inc;
   logic          cur_done;
   logic [2:0]    n;
   rsp_item_type [MAX_WRITES-1:0] w;

   assign pos_address = line_address(item.row, item.column);
   assign load_start  = (item.cmd == CMD_STR_CHAR || item.cmd == CMD_STR_END)
                        && item.string_start;
   assign cur_address = load_start ? pos_address : address_ff;
   assign cur_count   = load_start ? '0 : count_ff;
   assign cur_done    = load_start ? 1'b0 : done_ff;
   assign count_inc   = cur_count + CW'(1);

   always_comb begin
      n          = 3'd0;
      w          = '0;
      address_in = cur_address;
      count_in   = cur_count;
      done_in    = cur_done;
      unique case (item.cmd)
         CMD_INIT: begin
            w[0] = bus_write(1'b0, LCD_FUNCTION_SET);
            w[1] = bus_write(1'b0, LCD_DISPLAY_ON);
            w[2] = bus_write(1'b0, LCD_ENTRY_MODE);
            w[3] = bus_write(1'b0, LCD_CLEAR);
            n    = 3'd4;
         end
         CMD_CLEAR: begin
            w[0] = bus_write(1'b0, LCD_CLEAR);
            n    = 3'd1;
         end
         CMD_CHAR_AT: begin
            w[0] = bus_write(1'b0, pos_address);
            w[1] = bus_write(1'b1, item.char_code);
            n    = 3'd2;
         end
         CMD_STR_CHAR: begin
            if (!cur_done) begin
               w[0] = bus_write(1'b0, cur_address);
               if (cur_count >= LINE_LAST) begin
                  // line already full: only the closing address goes out
                  n          = 3'd1;
                  address_in = cur_address + 8'd1;
                  done_in    = 1'b1;
               end else begin
                  w[1]     = bus_write(1'b1, item.char_code);
                  count_in = count_inc;
                  if (count_inc >= LINE_LAST) begin
                     w[2]       = bus_write(1'b0, cur_address + 8'd1);
                     n          = 3'd3;
                     address_in = cur_address + 8'd2;
                     done_in    = 1'b1;
                  end else begin
                     n          = 3'd2;
                     address_in = cur_address + 8'd1;
                  end
               end
            end
         end
         CMD_STR_END: begin
            if (!cur_done) begin
               w[0]       = bus_write(1'b0, cur_address);
               n          = 3'd1;
               address_in = cur_address + 8'd1;
               done_in    = 1'b1;
            end
         end
         default: begin
            // unknown command: no writes, string state untouched
            address_in = address_ff;
            count_in   = count_ff;
            done_in    = done_ff;
         end
      endcase
      for (int i = 0; i < MAX_WRITES; i++) begin
         w[i].last = (3'(i) + 3'd1 == n);
      end
   end

   assign list.count  = n;
   assign list.writes = w;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= 8'd0;
         count_ff   <= '0;
         done_ff    <= 1'b0;
      end else if (commit) begin
         address_ff <= address_in;
         count_ff   <= count_in;
         done_ff    <= done_in;
      end
   end

   string_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LINE_LAST)
      else $error("string character count beyond line length");

   full_line_closed: assert property (@(posedge clock) disable iff (reset)
      count_ff == LINE_LAST |-> done_ff)
      else $error("full line without closing address");

endmodule

// ===== design/char_lcd_write_sequencer.sv =====
// top level of the character lcd write sequencer
//
//  port group  | direction | handshake              | carries
//  req_*       | in        | req_valid / req_ready  | one host command item
//  rsp_*       | out       | rsp_valid / rsp_ready  | one lcd bus write item
//  csr_*       | in/out    | apb setup + access     | setup_ticks, enable_ticks
//
// an item waits in the input register until the write buffer is free, then its
// writes are expanded into the buffer in a single pass and leave one per cycle
// while rsp_ready is high; an item gives 1 to 4 writes, none for ignored items.
// the next item is taken while the current writes drain; the buffer reloads in
// the cycle its last write is taken. reset clears the valid flags and the string
// state; a stall on rsp_ready backs up into req_ready.
module char_lcd_write_sequencer
   import lcdw_pkg::*;
#(
   parameter int LINE_CHARS = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic           s1_valid_ff, s1_valid_in;
   req_item_type   s1_item_ff;
   rsp_item_type [MAX_WRITES-1:0] buf_ff;
   logic [2:0]     buf_cnt_ff, buf_cnt_in;
   logic [1:0]     buf_idx_ff, buf_idx_in;
   write_list_type list;
   logic           last_take;
   logic           buf_free;
   logic           s1_move;
   logic           req_take;

   lcdw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lcdw_expand #(
      .LINE_CHARS (LINE_CHARS)
   ) u_expand (
      .clock  (clock),
      .reset  (reset),
      .item   (s1_item_ff),
      .commit (s1_move),
      .list   (list)
   );

   assign rsp_valid = (buf_cnt_ff != 3'd0);
   assign rsp_item  = buf_ff[buf_idx_ff];
   assign last_take = rsp_valid && rsp_ready && rsp_item.last;
   assign buf_free  = !rsp_valid || last_take;
   assign s1_move   = s1_valid_ff && buf_free;
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      buf_cnt_in = buf_cnt_ff;
      buf_idx_in = buf_idx_ff;
      priority if (s1_move) begin
         buf_cnt_in = list.count;
         buf_idx_in = 2'd0;
      end else if (last_take) begin
         buf_cnt_in = 3'd0;
      end else if (rsp_valid && rsp_ready) begin
         buf_idx_in = buf_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         buf_cnt_ff  <= 3'd0;
         buf_idx_ff  <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         buf_cnt_ff  <= buf_cnt_in;
         buf_idx_ff  <= buf_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (s1_move) begin
         buf_ff <= list.writes;
      end
   end

   index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, buf_idx_ff} < buf_cnt_ff))
      else $error("write buffer index past its count");

   last_marks_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.last == ({1'b0, buf_idx_ff} + 3'd1 == buf_cnt_ff)))
      else $error("last flag does not match final buffered write");

   more_after_non_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_item.last |=> rsp_valid)
      else $error("writes of an item lost before its last");

   held_item_stays: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !buf_free |=> s1_valid_ff)
      else $error("held item dropped while write buffer busy");

endmodule
